[rtl/core/cfnv_pkg.sv]
// shared constants, types and arithmetic helpers of the frustum vertex and normal evaluator
package cfnv_pkg;

  localparam int POS_W  = 24;
  localparam int NORM_W = 18;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_BOTTOM = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOP    = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic signed [CFG_W-1:0] CFG_RESET = 24'sd65536;

  // odd taylor coefficients of sin(pi/2 * t), q30
  localparam logic [31:0] C9_Q30 = 32'd172272;
  localparam logic [31:0] HORNER_C [0:3] = '{32'd5026995, 32'd85569306,
                                             32'd693598668, 32'd1686629713};

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam int SQ_FIRST   = 15;
  localparam int DIV_FIRST  = SQ_FIRST + SQRT_STEPS;
  localparam int OUT_STAGE  = DIV_FIRST + DIV_STEPS;
  localparam int PIPE_DEPTH = OUT_STAGE + 1;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [2:0]              sgn;
    logic                    deg;
    logic [29:0]             mag_x;
    logic [29:0]             mag_y;
    logic [29:0]             mag_z;
  } carry_t;

  // q30 product rounded half up, operands nonnegative
  function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b + 64'd536870912;
    return p[61:30];
  endfunction

  // drop 16 fraction bits, ties away from zero
  function automatic logic signed [47:0] rnd16(input logic signed [47:0] x);
    logic [47:0] m;
    m = (x < 0) ? 48'(-x) : 48'(x);
    m = (m + 48'd32768) >> 16;
    return (x < 0) ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [47:0] x);
    if (x > 48'sd8388607) return 24'sh7fffff;
    if (x < -48'sd8388608) return 24'sh800000;
    return x[POS_W-1:0];
  endfunction

endpackage

[rtl/core/cone_frustum_vertex_normal_eval.sv]
// cone frustum vertex and unit normal evaluator, fully pipelined
//
//  channel   handshake              payload
//  input     start / busy           in_turn_fraction, in_axial_fraction
//  result    out_valid strobe       out_pos_*, out_norm_*, out_degenerate_normal
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle
// the pipeline includes the 32 step square root and the 17 step divider chains
// busy is never raised and cfg_ready is always high
// synchronous reset clears the valid chain and sets the radius/height registers to 65536
// the receiver cannot stall, so the pipeline advances every cycle
module cone_frustum_vertex_normal_eval
  import cfnv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [15:0]              in_turn_fraction,
  input  logic [16:0]              in_axial_fraction,
  output logic                     out_valid,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic signed [POS_W-1:0]  out_pos_z,
  output logic signed [NORM_W-1:0] out_norm_x,
  output logic signed [NORM_W-1:0] out_norm_y,
  output logic signed [NORM_W-1:0] out_norm_z,
  output logic                     out_degenerate_normal,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  logic signed [CFG_W-1:0] rb_r, rt_r, h_r;
  logic                    vld_r [0:PIPE_DEPTH-1];
  logic                    accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r <= CFG_RESET;
      rt_r <= CFG_RESET;
      h_r  <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOTTOM: rb_r <= cfg_data;
        REG_TOP:    rt_r <= cfg_data;
        REG_HEIGHT: h_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 0: input capture
  logic [15:0] u0_r;
  logic [16:0] v0_r;
  always_ff @(posedge clk) begin
    u0_r <= in_turn_fraction;
    v0_r <= in_axial_fraction;
  end

  // stage 1: quadrant folding (lane 0 cosine, lane 1 sine), axial products
  logic [31:0]        t1_r [0:1];
  logic [1:0]         q1_r [0:1];
  logic signed [42:0] prodr1_r;
  logic signed [41:0] prodz1_r;
  always_ff @(posedge clk) begin
    logic [15:0]        ph;
    logic [14:0]        f;
    logic signed [24:0] rdiff;
    for (int l = 0; l < 2; l++) begin
      ph = (l == 0) ? u0_r + 16'd16384 : u0_r;
      f  = ph[14] ? 15'd16384 - {1'b0, ph[13:0]} : {1'b0, ph[13:0]};
      t1_r[l] <= {1'b0, f, 16'b0};
      q1_r[l] <= ph[15:14];
    end
    rdiff = {rt_r[CFG_W-1], rt_r} - {rb_r[CFG_W-1], rb_r};
    prodr1_r <= rdiff * signed'({1'b0, v0_r});
    prodz1_r <= h_r * signed'({1'b0, v0_r});
  end

  // stage 2: t squared, radius and z
  logic [31:0]             t2_r [0:1];
  logic [31:0]             tk2_r [0:1];
  logic [1:0]              q2_r [0:1];
  logic signed [27:0]      r2_r;
  logic signed [POS_W-1:0] pz2_r;
  always_ff @(posedge clk) begin
    logic signed [47:0] rsum;
    for (int l = 0; l < 2; l++) begin
      t2_r[l]  <= mul_q30(t1_r[l], t1_r[l]);
      tk2_r[l] <= t1_r[l];
      q2_r[l]  <= q1_r[l];
    end
    rsum  = {{24{rb_r[CFG_W-1]}}, rb_r} + rnd16({{5{prodr1_r[42]}}, prodr1_r});
    r2_r  <= rsum[27:0];
    pz2_r <= sat24(rnd16({{6{prodz1_r[41]}}, prodz1_r}));
  end

  // stages 3 to 6: horner steps of the sine polynomial
  logic [31:0]             hacc_r [0:3][0:1];
  logic [31:0]             ht_r   [0:3][0:1];
  logic [31:0]             ht2_r  [0:3][0:1];
  logic [1:0]              hq_r   [0:3][0:1];
  logic signed [27:0]      rd_r   [0:4];
  logic signed [POS_W-1:0] pzd_r  [0:4];

  for (genvar h = 0; h < 4; h++) begin : g_horner
    if (h == 0) begin : g_head
      always_ff @(posedge clk) begin
        for (int l = 0; l < 2; l++) begin
          hacc_r[h][l] <= HORNER_C[h] - mul_q30(t2_r[l], C9_Q30);
          ht_r[h][l]   <= tk2_r[l];
          ht2_r[h][l]  <= t2_r[l];
          hq_r[h][l]   <= q2_r[l];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        for (int l = 0; l < 2; l++) begin
          hacc_r[h][l] <= HORNER_C[h] - mul_q30(ht2_r[h-1][l], hacc_r[h-1][l]);
          ht_r[h][l]   <= ht_r[h-1][l];
          ht2_r[h][l]  <= ht2_r[h-1][l];
          hq_r[h][l]   <= hq_r[h-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r[0]  <= r2_r;
    pzd_r[0] <= pz2_r;
    for (int i = 1; i < 5; i++) begin
      rd_r[i]  <= rd_r[i-1];
      pzd_r[i] <= pzd_r[i-1];
    end
  end

  // stage 7: final product, round to q16, clamp, quadrant sign
  logic signed [17:0] sc7_r [0:1];
  always_ff @(posedge clk) begin
    logic [32:0] mr;
    logic [18:0] mg;
    logic [16:0] m17;
    for (int l = 0; l < 2; l++) begin
      mr  = {1'b0, mul_q30(ht_r[3][l], hacc_r[3][l])} + 33'd8192;
      mg  = mr[32:14];
      m17 = (mg > 19'd65536) ? 17'd65536 : mg[16:0];
      sc7_r[l] <= hq_r[3][l][1] ? -signed'({1'b0, m17}) : signed'({1'b0, m17});
    end
  end

  // stage 8: vertex and normal products
  logic signed [45:0]      pxp8_r, pyp8_r;
  logic signed [41:0]      chp8_r, shp8_r;
  logic signed [POS_W-1:0] pz8_r;
  always_ff @(posedge clk) begin
    pxp8_r <= sc7_r[0] * rd_r[4];
    pyp8_r <= sc7_r[1] * rd_r[4];
    chp8_r <= sc7_r[0] * h_r;
    shp8_r <= sc7_r[1] * h_r;
    pz8_r  <= pzd_r[4];
  end

  // stage 9: vertex rounding and saturation, normal magnitudes
  logic signed [POS_W-1:0] px9_r, py9_r, pz9_r;
  logic [40:0]             mag9_r [0:2];
  logic [2:0]              sgn9_r;
  always_ff @(posedge clk) begin
    logic signed [24:0] rdz;
    logic [24:0]        az;
    px9_r <= sat24(rnd16({{2{pxp8_r[45]}}, pxp8_r}));
    py9_r <= sat24(rnd16({{2{pyp8_r[45]}}, pyp8_r}));
    pz9_r <= pz8_r;
    rdz = {rb_r[CFG_W-1], rb_r} - {rt_r[CFG_W-1], rt_r};
    az  = (rdz < 0) ? 25'(-rdz) : 25'(rdz);
    mag9_r[0] <= (chp8_r < 0) ? 41'(-chp8_r) : chp8_r[40:0];
    mag9_r[1] <= (shp8_r < 0) ? 41'(-shp8_r) : shp8_r[40:0];
    mag9_r[2] <= {az[23:0], 16'b0} | {az[24], 40'b0};
    sgn9_r    <= {rdz < 0, shp8_r < 0, chp8_r < 0};
  end

  carry_t cr_r [10:OUT_STAGE-1];

  // stage 10: largest magnitude
  logic [40:0] mx10_r;
  logic [40:0] mag10_r [0:2];
  always_ff @(posedge clk) begin
    logic [40:0] m01;
    m01 = (mag9_r[1] > mag9_r[0]) ? mag9_r[1] : mag9_r[0];
    mx10_r <= (mag9_r[2] > m01) ? mag9_r[2] : m01;
    for (int i = 0; i < 3; i++) mag10_r[i] <= mag9_r[i];
    cr_r[10] <= '{px: px9_r, py: py9_r, pz: pz9_r, sgn: sgn9_r,
                  deg: (mag9_r[0] | mag9_r[1] | mag9_r[2]) == '0,
                  mag_x: '0, mag_y: '0, mag_z: '0};
  end

  // stage 11: bit length of the largest magnitude
  logic [5:0]  bl11_r;
  logic [40:0] mag11_r [0:2];
  always_ff @(posedge clk) begin
    logic [5:0] bl;
    bl = '0;
    for (int i = 0; i < 41; i++) if (mx10_r[i]) bl = 6'(i + 1);
    bl11_r <= bl;
    for (int i = 0; i < 3; i++) mag11_r[i] <= mag10_r[i];
    cr_r[11] <= cr_r[10];
  end

  // stage 12: common normalising shift, right shift truncates
  logic [29:0] nm12 [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl11_r > 6'd30) nm12[i] = 30'(mag11_r[i] >> (bl11_r - 6'd30));
      else nm12[i] = 30'(mag11_r[i] << (6'd30 - bl11_r));
    end
  end

  always_ff @(posedge clk) begin
    carry_t c12;
    c12       = cr_r[11];
    c12.mag_x = nm12[0];
    c12.mag_y = nm12[1];
    c12.mag_z = nm12[2];
    cr_r[12] <= c12;
  end

  for (genvar s = 13; s < OUT_STAGE; s++) begin : g_carry
    always_ff @(posedge clk) cr_r[s] <= cr_r[s-1];
  end

  // stages 13 and 14: squares and their sum
  logic [59:0] sq13_r [0:2];
  logic [62:0] sum14_r;
  always_ff @(posedge clk) begin
    sq13_r[0] <= cr_r[12].mag_x * cr_r[12].mag_x;
    sq13_r[1] <= cr_r[12].mag_y * cr_r[12].mag_y;
    sq13_r[2] <= cr_r[12].mag_z * cr_r[12].mag_z;
    sum14_r   <= 63'(sq13_r[0]) + 63'(sq13_r[1]) + 63'(sq13_r[2]);
  end

  // square root, one result bit a stage
  logic [62:0] sqn_r   [0:SQRT_STEPS-1];
  logic [62:0] sqres_r [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
    logic [62:0] n_in, res_in;
    if (k == 0) begin : g_head
      assign n_in   = sum14_r;
      assign res_in = '0;
    end else begin : g_tail
      assign n_in   = sqn_r[k-1];
      assign res_in = sqres_r[k-1];
    end
    always_ff @(posedge clk) begin
      logic [63:0] trial;
      trial = {1'b0, res_in} + {1'b0, BIT};
      if ({1'b0, n_in} >= trial) begin
        sqn_r[k]   <= n_in - trial[62:0];
        sqres_r[k] <= (res_in >> 1) + BIT;
      end else begin
        sqn_r[k]   <= n_in;
        sqres_r[k] <= res_in >> 1;
      end
    end
  end

  // restoring division, one quotient bit a stage, three lanes
  logic [47:0] divr_r [0:DIV_STEPS-1][0:2];
  logic [16:0] divq_r [0:DIV_STEPS-1][0:2];
  logic [32:0] divd_r [0:DIV_STEPS-1];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [32:0] d_in;
    logic [47:0] r_in [0:2];
    logic [16:0] q_in [0:2];
    if (j == 0) begin : g_head
      assign d_in    = {sqres_r[SQRT_STEPS-1][31:0], 1'b0};
      assign r_in[0] = {1'b0, cr_r[DIV_FIRST-1].mag_x, 17'b0} +
                       48'(sqres_r[SQRT_STEPS-1][31:0]);
      assign r_in[1] = {1'b0, cr_r[DIV_FIRST-1].mag_y, 17'b0} +
                       48'(sqres_r[SQRT_STEPS-1][31:0]);
      assign r_in[2] = {1'b0, cr_r[DIV_FIRST-1].mag_z, 17'b0} +
                       48'(sqres_r[SQRT_STEPS-1][31:0]);
      assign q_in[0] = '0;
      assign q_in[1] = '0;
      assign q_in[2] = '0;
    end else begin : g_tail
      assign d_in = divd_r[j-1];
      assign r_in = divr_r[j-1];
      assign q_in = divq_r[j-1];
    end
    always_ff @(posedge clk) begin
      logic [48:0] dk;
      divd_r[j] <= d_in;
      dk = 49'(d_in) << (DIV_STEPS - 1 - j);
      for (int l = 0; l < 3; l++) begin
        if ({1'b0, r_in[l]} >= dk) begin
          divr_r[j][l] <= r_in[l] - dk[47:0];
          divq_r[j][l] <= q_in[l] | (17'd1 << (DIV_STEPS - 1 - j));
        end else begin
          divr_r[j][l] <= r_in[l];
          divq_r[j][l] <= q_in[l];
        end
      end
    end
  end

  // output stage
  logic signed [NORM_W-1:0] nrm_r [0:2];
  logic signed [POS_W-1:0]  opx_r, opy_r, opz_r;
  logic                     odeg_r;
  always_ff @(posedge clk) begin
    logic [16:0] qc;
    for (int l = 0; l < 3; l++) begin
      qc = (divq_r[DIV_STEPS-1][l] > 17'd65536) ? 17'd65536 : divq_r[DIV_STEPS-1][l];
      if (cr_r[OUT_STAGE-1].deg) nrm_r[l] <= '0;
      else if (cr_r[OUT_STAGE-1].sgn[l]) nrm_r[l] <= -signed'({1'b0, qc});
      else nrm_r[l] <= signed'({1'b0, qc});
    end
    opx_r  <= cr_r[OUT_STAGE-1].px;
    opy_r  <= cr_r[OUT_STAGE-1].py;
    opz_r  <= cr_r[OUT_STAGE-1].pz;
    odeg_r <= cr_r[OUT_STAGE-1].deg;
  end

  assign out_valid             = vld_r[PIPE_DEPTH-1];
  assign out_pos_x             = opx_r;
  assign out_pos_y             = opy_r;
  assign out_pos_z             = opz_r;
  assign out_norm_x            = nrm_r[0];
  assign out_norm_y            = nrm_r[1];
  assign out_norm_z            = nrm_r[2];
  assign out_degenerate_normal = odeg_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_DEPTH out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_DEPTH))
    else $error("result without an accepted transaction");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate_normal) |->
      (out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0))
    else $error("degenerate normal not zero");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_x <= 18'sd65536 && out_norm_x >= -18'sd65536 &&
                   out_norm_y <= 18'sd65536 && out_norm_y >= -18'sd65536 &&
                   out_norm_z <= 18'sd65536 && out_norm_z >= -18'sd65536))
    else $error("normal component out of range");

endmodule
